/* rtl/piecewise_linear_playback_assert.svh */
// Assertion macros used by the playback RTL (plp_back).
`ifndef PIECEWISE_LINEAR_PLAYBACK_ASSERT_SVH
`define PIECEWISE_LINEAR_PLAYBACK_ASSERT_SVH
`ifndef SYNTH
`define PLP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("%m: invariant violated");
`define PLP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication violated");
`else
`define PLP_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define PLP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/plp_pkg.sv */
`default_nettype none
package plp_pkg;
	localparam int ACTION_W = 2;
	localparam int IDX_W    = 8;
	localparam int COUNT_W  = 9;

	localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_EVAL    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_DELIVER = 2'd2;

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_EVAL    = 2'd1;
	localparam logic [1:0] KIND_DELIVER = 2'd2;
	localparam logic [1:0] KIND_NOP     = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic             in_range;
		logic [IDX_W-1:0] idx;
	} plp_cmd_t;
endpackage
`default_nettype wire

/* rtl/plp_front.sv */
`default_nettype none
module plp_front #(
	parameter int DW    = 32,
	parameter int DEPTH = 256
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [plp_pkg::ACTION_W-1:0] in_action,
	input  wire  [plp_pkg::IDX_W-1:0]    in_idx,
	input  wire  [DW-1:0]                in_etime,
	input  wire  [DW-1:0]                in_evalue,
	input  wire  [DW-1:0]                in_qtime,
	output logic                         q_valid,
	input  wire                          q_ready,
	output plp_pkg::plp_cmd_t            q_cmd,
	output logic [DW-1:0]                q_etime,
	output logic [DW-1:0]                q_evalue,
	output logic [DW-1:0]                q_qtime
);
	import plp_pkg::*;

	plp_cmd_t    cmd_new;
	plp_cmd_t    cmd_mem_q   [2];
	logic [DW-1:0] etime_mem_q [2];
	logic [DW-1:0] evalue_mem_q[2];
	logic [DW-1:0] qtime_mem_q [2];
	logic [1:0]  count_q;
	logic        wp_q;
	logic        rp_q;
	logic        push;
	logic        pop;

	// classify the action
	always_comb begin
		cmd_new.idx      = in_idx;
		cmd_new.in_range = ({24'd0, in_idx} < 32'(DEPTH));
		unique case (in_action)
			ACT_LOAD:    cmd_new.kind = KIND_LOAD;
			ACT_EVAL:    cmd_new.kind = KIND_EVAL;
			ACT_DELIVER: cmd_new.kind = KIND_DELIVER;
			default:     cmd_new.kind = KIND_NOP;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem_q[wp_q]    <= cmd_new;
			etime_mem_q[wp_q]  <= in_etime;
			evalue_mem_q[wp_q] <= in_evalue;
			qtime_mem_q[wp_q]  <= in_qtime;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	assign q_cmd    = cmd_mem_q[rp_q];
	assign q_etime  = etime_mem_q[rp_q];
	assign q_evalue = evalue_mem_q[rp_q];
	assign q_qtime  = qtime_mem_q[rp_q];
endmodule
`default_nettype wire

/* rtl/plp_muldiv.sv */
`default_nettype none
// Unsigned floor(a*b/d): shift-add multiply, then restoring division, one bit a cycle.
module plp_muldiv #(
	parameter int W = 33
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire  [W-1:0]   a,
	input  wire  [W-1:0]   b,
	input  wire  [W-1:0]   d,
	output logic           done,
	output logic [2*W-1:0] quot
);
	localparam int PW   = 2 * W;
	localparam int CNTW = $clog2(PW + 1);
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;

	logic [1:0]      phase_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [PW-1:0]   mc_q;
	logic [W-1:0]    mb_q;
	logic [PW-1:0]   acc_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    d_q;
	logic [W:0]      rem_sh;
	logic [W:0]      diff;
	logic            ge;

	assign rem_sh = {rem_q, acc_q[PW-1]};
	assign diff   = rem_sh - {1'b0, d_q};
	assign ge     = (rem_sh >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
						cnt_q   <= CNTW'(W);
					end
				end
				PH_MUL: begin
					if (cnt_q == CNTW'(1)) begin
						phase_q <= PH_DIV;
						cnt_q   <= CNTW'(PW);
					end else begin
						cnt_q <= cnt_q - CNTW'(1);
					end
				end
				PH_DIV: begin
					if (cnt_q == CNTW'(1)) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - CNTW'(1);
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) begin
			mc_q  <= PW'(a);
			mb_q  <= b;
			d_q   <= d;
			acc_q <= '0;
			rem_q <= '0;
		end else if (phase_q == PH_MUL) begin
			if (mb_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[PW-2:0], 1'b0};
			mb_q <= {1'b0, mb_q[W-1:1]};
		end else if (phase_q == PH_DIV) begin
			rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
			acc_q <= {acc_q[PW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = acc_q;
endmodule
`default_nettype wire

/* rtl/plp_back.sv */
`default_nettype none
`include "piecewise_linear_playback_assert.svh"
module plp_back #(
	parameter int DW    = 32,
	parameter int DEPTH = 256
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [plp_pkg::COUNT_W-1:0] entry_count,
	input  wire                         q_valid,
	output logic                        q_ready,
	input  plp_pkg::plp_cmd_t           q_cmd,
	input  wire  [DW-1:0]               q_etime,
	input  wire  [DW-1:0]               q_evalue,
	input  wire  [DW-1:0]               q_qtime,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [DW-1:0]               out_play,
	output logic                        out_written,
	output logic [DW-1:0]               out_next_time,
	output logic                        out_next_valid
);
	import plp_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int W  = DW + 1;
	localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_UB    = 4'd1;
	localparam logic [3:0] S_FIRST = 4'd2;
	localparam logic [3:0] S_DOWN  = 4'd3;
	localparam logic [3:0] S_UP    = 4'd4;
	localparam logic [3:0] S_SET   = 4'd5;
	localparam logic [3:0] S_T1    = 4'd6;
	localparam logic [3:0] S_T0    = 4'd7;
	localparam logic [3:0] S_CALC  = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_SUM   = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0]           state_q;
	logic [DW-1:0]        time_mem_q  [DEPTH];
	logic [DW-1:0]        value_mem_q [DEPTH];
	logic signed [DW-1:0] t_rd_q;
	logic signed [DW-1:0] v_rd_q;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        ub_q;
	logic [AW-1:0]        cur_q;
	logic [AW-1:0]        c_q;
	logic signed [DW-1:0] qtime_q;
	logic signed [DW-1:0] t0_q, t1_q, x0_q, x1_q;
	logic                 neg_q;
	logic [DW-1:0]        res_val_q;
	logic                 res_wr_q;
	logic [DW-1:0]        nextt_q;
	logic                 nev_q;
	logic                 out_valid_q;
	logic [DW-1:0]        out_play_q;
	logic                 out_wr_q;
	logic [DW-1:0]        out_nt_q;
	logic                 out_nv_q;

	logic [CW-1:0]        ec;
	logic [CW-1:0]        used;
	logic                 adv;
	logic                 start;
	logic                 mem_we;
	logic                 down_go;
	logic                 up_go;
	logic [AW-1:0]        cstart;
	logic [AW-1:0]        cfin;
	logic signed [W-1:0]  dx, dt, den;
	logic [W-1:0]         mdx, mdt, mden;
	logic signed [W-1:0]  avg_sum;
	logic [W-1:0]         avg_adj;
	logic                 md_start;
	logic                 md_done;
	logic [2*W-1:0]       md_quot;
	logic [W-1:0]         qmag;
	logic signed [W:0]    sq;
	logic signed [W+1:0]  total;
	logic [DW-1:0]        sat_val;
	logic                 out_free;

	// bound advance follows the clamped breakpoint count
	always_comb begin
		ec = CW'(entry_count);
		if (ec == '0) used = CW'(1);
		else if (ec > CW'(DEPTH)) used = CW'(DEPTH);
		else used = ec;
	end
	assign adv      = (q_cmd.kind == KIND_DELIVER) && ((CW'(ub_q) + CW'(1)) < used);
	assign q_ready  = (state_q == S_IDLE);
	assign start    = q_valid && q_ready;
	assign mem_we   = start && (q_cmd.kind == KIND_LOAD) && q_cmd.in_range;
	assign down_go  = (c_q != '0) && (qtime_q < t_rd_q);
	assign up_go    = (c_q != ub_q) && (qtime_q >= t_rd_q);
	assign cstart   = (cur_q > ub_q) ? ub_q : cur_q;
	assign cfin     = (c_q == '0) ? AW'(1) : c_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = adv ? ub_q + AW'(1) : ub_q;
			S_UB:    rd_addr = '0;
			S_FIRST: rd_addr = cstart;
			S_DOWN:  rd_addr = down_go ? c_q - AW'(1) : c_q + AW'(1);
			S_UP:    rd_addr = c_q + AW'(1);
			S_SET:   rd_addr = cfin;
			S_T1:    rd_addr = c_q - AW'(1);
			default: rd_addr = c_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			time_mem_q[AW'(q_cmd.idx)]  <= q_etime;
			value_mem_q[AW'(q_cmd.idx)] <= q_evalue;
		end
		t_rd_q <= time_mem_q[rd_addr];
		v_rd_q <= value_mem_q[rd_addr];
	end

	// interpolation operands
	assign dx   = W'(x1_q) - W'(x0_q);
	assign dt   = W'(qtime_q) - W'(t0_q);
	assign den  = W'(t1_q) - W'(t0_q);
	assign mdx  = dx[W-1] ? -dx : dx;
	assign mdt  = dt[W-1] ? -dt : dt;
	assign mden = den[W-1] ? -den : den;
	assign avg_sum = W'(x0_q) + W'(x1_q);
	assign avg_adj = avg_sum + W'(avg_sum[W-1]);
	assign md_start = (state_q == S_CALC) && (t0_q != t1_q);

	plp_muldiv #(.W(W)) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.a      (mdx),
		.b      (mdt),
		.d      (mden),
		.done   (md_done),
		.quot   (md_quot)
	);

	// clamp the quotient well past the data range, then saturate the sum
	assign qmag  = (|md_quot[2*W-1:W]) ? {W{1'b1}} : md_quot[W-1:0];
	assign sq    = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
	assign total = (W+2)'(x0_q) + (W+2)'(sq);
	always_comb begin
		if ((&total[W+1:DW-1]) || !(|total[W+1:DW-1])) sat_val = total[DW-1:0];
		else if (total[W+1]) sat_val = {1'b1, {(DW-1){1'b0}}};
		else sat_val = {1'b0, {(DW-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				qtime_q   <= q_qtime;
				res_val_q <= '0;
				res_wr_q  <= 1'b0;
				nextt_q   <= '0;
			end
			S_UB: begin
				if (nev_q) nextt_q <= t_rd_q;
				if (qtime_q >= t_rd_q && ub_q == '0) begin
					res_val_q <= v_rd_q;
					res_wr_q  <= 1'b1;
				end
			end
			S_FIRST: begin
				if (qtime_q <= t_rd_q) begin
					res_val_q <= v_rd_q;
					res_wr_q  <= 1'b1;
				end
			end
			S_T1: begin
				t1_q <= t_rd_q;
				x1_q <= v_rd_q;
			end
			S_T0: begin
				t0_q <= t_rd_q;
				x0_q <= v_rd_q;
			end
			S_CALC: begin
				neg_q     <= dx[W-1] ^ dt[W-1] ^ den[W-1];
				res_val_q <= avg_adj[W-1:1];
				res_wr_q  <= 1'b1;
			end
			S_SUM: res_val_q <= sat_val;
			default: res_wr_q <= res_wr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ub_q        <= '0;
			cur_q       <= '0;
			c_q         <= '0;
			nev_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// raise on a new result, drop once the waiting one is taken
			priority if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						nev_q <= 1'b0;
						priority if (q_cmd.kind == KIND_LOAD) begin
							ub_q    <= '0;
							cur_q   <= '0;
							state_q <= S_OUT;
						end else if (q_cmd.kind == KIND_NOP) begin
							state_q <= S_OUT;
						end else begin
							if (adv) begin
								ub_q  <= ub_q + AW'(1);
								nev_q <= 1'b1;
							end
							state_q <= S_UB;
						end
					end
				end
				S_UB: begin
					if (qtime_q >= t_rd_q) begin
						cur_q   <= ub_q;
						state_q <= S_OUT;
					end else begin
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					if (qtime_q <= t_rd_q) begin
						state_q <= S_OUT;
					end else begin
						c_q     <= cstart;
						state_q <= S_DOWN;
					end
				end
				S_DOWN: begin
					priority if (down_go) c_q <= c_q - AW'(1);
					else if (up_go) begin
						c_q     <= c_q + AW'(1);
						state_q <= S_UP;
					end else state_q <= S_SET;
				end
				S_UP: begin
					if (up_go) c_q <= c_q + AW'(1);
					else state_q <= S_SET;
				end
				S_SET: begin
					c_q     <= cfin;
					cur_q   <= cfin;
					state_q <= S_T1;
				end
				S_T1: state_q <= S_T0;
				S_T0: state_q <= S_CALC;
				S_CALC: state_q <= (t0_q == t1_q) ? S_OUT : S_DIV;
				S_DIV: if (md_done) state_q <= S_SUM;
				S_SUM: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_play_q <= res_val_q;
			out_wr_q   <= res_wr_q;
			out_nt_q   <= nev_q ? nextt_q : '0;
			out_nv_q   <= nev_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_play       = out_play_q;
	assign out_written    = out_wr_q;
	assign out_next_time  = out_nt_q;
	assign out_next_valid = out_nv_q;

	`PLP_ASSERT_ALWAYS(a_cursor_in_bound, clk, arst_n, cur_q <= ub_q)
	`PLP_ASSERT_IMPL(a_sum_after_div, clk, arst_n, state_q == S_SUM, $past(md_done))
	`PLP_ASSERT_IMPL(a_walk_in_bound, clk, arst_n, state_q == S_DOWN || state_q == S_UP, c_q <= ub_q)
	`PLP_ASSERT_IMPL(a_no_nev_zero_ub, clk, arst_n, nev_q && state_q == S_OUT, ub_q != '0)
endmodule
`default_nettype wire

/* rtl/piecewise_linear_playback.sv */
`default_nettype none
// Piecewise-linear playback table. Load items write one time/value breakpoint
// (signed Q16.16) into slot entry_index and return the bound and cursor to the
// first entry; evaluate items return the curve value at query_time; deliver
// items first advance the upper-bound breakpoint (while entries remain, as set
// by the entry_count register) and report its time, then evaluate. Each item
// yields exactly one result. The cursor walks one table read a cycle through
// the breakpoint memory, and the multiply/divide unit works one bit per cycle.
// Items queue two deep at the input and one result waits in the output
// register, so both sides can stall freely. Write entry_count only while the
// block is idle.
module piecewise_linear_playback #(
	parameter int TABLE_DEPTH = 256,
	parameter int DATA_WIDTH  = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_axis_tvalid,
	output logic                        s_axis_tready,
	// entry_index, entry_time, entry_value, query_time, zero pad
	input  wire  [((plp_pkg::IDX_W + 3*DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// action
	input  wire  [plp_pkg::ACTION_W-1:0] s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire                         m_axis_tready,
	// play_value, next_event_time, zero pad
	output logic [((2*DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// value_written, next_event_valid
	output logic [1:0]                  m_axis_tuser,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  [plp_pkg::COUNT_W-1:0] cfg_data
);
	import plp_pkg::*;

	localparam int OW = ((2*DATA_WIDTH + 7) / 8) * 8;
	localparam int DW = DATA_WIDTH;

	logic [COUNT_W-1:0] entry_count_q;
	logic               q_valid;
	logic               q_ready;
	plp_cmd_t           q_cmd;
	logic [DW-1:0]      q_etime;
	logic [DW-1:0]      q_evalue;
	logic [DW-1:0]      q_qtime;
	logic [DW-1:0]      play;
	logic               written;
	logic [DW-1:0]      next_time;
	logic               next_valid;

	// configuration: always ready, take the count on each write
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= COUNT_W'(1);
		end else if (cfg_valid) begin
			entry_count_q <= cfg_data;
		end
	end

	// front: classify items and hold them in the short queue
	plp_front #(.DW(DW), .DEPTH(TABLE_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_idx    (s_axis_tdata[IDX_W-1:0]),
		.in_etime  (s_axis_tdata[IDX_W +: DW]),
		.in_evalue (s_axis_tdata[IDX_W + DW +: DW]),
		.in_qtime  (s_axis_tdata[IDX_W + 2*DW +: DW]),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.q_etime   (q_etime),
		.q_evalue  (q_evalue),
		.q_qtime   (q_qtime)
	);

	// back: table memory, cursor walk, interpolation, result register
	plp_back #(.DW(DW), .DEPTH(TABLE_DEPTH)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.entry_count    (entry_count_q),
		.q_valid        (q_valid),
		.q_ready        (q_ready),
		.q_cmd          (q_cmd),
		.q_etime        (q_etime),
		.q_evalue       (q_evalue),
		.q_qtime        (q_qtime),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_play       (play),
		.out_written    (written),
		.out_next_time  (next_time),
		.out_next_valid (next_valid)
	);

	// pack the result item
	assign m_axis_tdata = OW'({next_time, play});
	assign m_axis_tuser = {next_valid, written};
endmodule
`default_nettype wire

/* verif/tb_piecewise_linear_playback.sv */
`timescale 1ns / 1ps
module tb_piecewise_linear_playback;
	import plp_pkg::*;

	localparam int DW         = 32;
	localparam int DEPTH      = 256;
	localparam int IDLE_LIMIT = 20000;
	localparam int TARGET     = 1350;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	// one result item as it leaves the block
	typedef struct {
		logic [DW-1:0] play;
		logic          written;
		logic [DW-1:0] next_time;
		logic          next_valid;
	} playback_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	wire           s_axis_tready;
	// entry_index, entry_time, entry_value, query_time (lowest bit up)
	logic [103:0]  s_axis_tdata = '0;
	// action
	logic [ACTION_W-1:0] s_axis_tuser = '0;
	wire           m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	// play_value, next_event_time (lowest bit up)
	wire  [63:0]   m_axis_tdata;
	// value_written, next_event_valid
	wire  [1:0]    m_axis_tuser;
	logic          cfg_valid = 1'b0;
	wire           cfg_ready;
	logic [COUNT_W-1:0] cfg_data = '0;

	// shadow copy of the breakpoint store and the playback pointers
	logic signed [DW-1:0] bp_time [DEPTH];
	logic signed [DW-1:0] bp_value [DEPTH];
	bit                   bp_written [DEPTH];
	int                   bound_idx;
	int                   cursor_idx;
	int                   count_reg;

	playback_result_t pending_results[$];
	int  items_sent;
	int  fail_count = 0;
	int  idle_cycles = 0;
	int  sink_hold = 0;
	bit  src_calm;
	bit  sink_calm;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	piecewise_linear_playback #(
		.TABLE_DEPTH(DEPTH),
		.DATA_WIDTH(DW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int used_entries();
		if (count_reg == 0)
			return 1;
		if (count_reg > DEPTH)
			return DEPTH;
		return count_reg;
	endfunction

	// Evaluate the curve at q; returns 1 when a value is produced.
	function automatic bit curve_at(logic signed [DW-1:0] q, output logic [DW-1:0] val);
		int c;
		longint t0, t1, x0, x1, dx, dt, den, sq, r;
		logic [63:0] mdx, mdt, mden;
		logic [127:0] prod, mq;
		bit neg;
		val = '0;
		if (q >= bp_time[bound_idx]) begin
			cursor_idx = bound_idx;
			if (bound_idx == 0) begin
				val = bp_value[0];
				return 1;
			end
			return 0;
		end
		if (q <= bp_time[0]) begin
			val = bp_value[0];
			return 1;
		end
		// walk down, then up, never leaving [0, bound]
		c = (cursor_idx > bound_idx) ? bound_idx : cursor_idx;
		while (c > 0 && q < bp_time[c])
			c--;
		while (c < bound_idx && q >= bp_time[c])
			c++;
		if (c == 0)
			c = 1;
		cursor_idx = c;
		t0 = bp_time[c-1];
		t1 = bp_time[c];
		x0 = bp_value[c-1];
		x1 = bp_value[c];
		if (t0 == t1) begin
			r = (x0 + x1) / 2;
		end else begin
			dx   = x1 - x0;
			dt   = longint'(q) - t0;
			den  = t1 - t0;
			mdx  = (dx < 0) ? -dx : dx;
			mdt  = (dt < 0) ? -dt : dt;
			mden = (den < 0) ? -den : den;
			neg  = ((dx < 0) != (dt < 0)) != (den < 0);
			prod = {64'b0, mdx} * {64'b0, mdt};
			mq   = prod / {64'b0, mden};
			if (mq > 128'h1FFF_FFFF_FFFF_FFFF)
				mq = 128'h1FFF_FFFF_FFFF_FFFF;
			sq = neg ? -longint'(mq[63:0]) : longint'(mq[63:0]);
			r  = x0 + sq;
		end
		// saturate to the signed data range
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		val = r[DW-1:0];
		return 1;
	endfunction

	// Apply one accepted item to the shadow state and return its result.
	function automatic playback_result_t playback_predict(logic [ACTION_W-1:0] act,
			logic [7:0] idx, logic [DW-1:0] et, logic [DW-1:0] ev, logic [DW-1:0] q);
		playback_result_t res;
		logic [DW-1:0] val;
		res = '{default: '0};
		if (act == ACT_LOAD) begin
			bp_time[idx]    = et;
			bp_value[idx]   = ev;
			bp_written[idx] = 1'b1;
			bound_idx  = 0;
			cursor_idx = 0;
		end else if (act == ACT_EVAL || act == ACT_DELIVER) begin
			if (act == ACT_DELIVER && bound_idx + 1 < used_entries()) begin
				bound_idx++;
				res.next_time  = bp_time[bound_idx];
				res.next_valid = 1'b1;
			end
			res.written = curve_at(q, val);
			res.play    = res.written ? val : '0;
		end
		return res;
	endfunction

	// An evaluation must never touch a slot that was never loaded.
	function automatic bit reads_loaded(bit deliver);
		int top;
		top = bound_idx;
		if (deliver && bound_idx + 1 < used_entries())
			top = bound_idx + 1;
		for (int i = 0; i <= top; i++)
			if (!bp_written[i])
				return 0;
		return 1;
	endfunction

	task automatic send_item(logic [ACTION_W-1:0] act, logic [7:0] idx,
			logic [DW-1:0] et, logic [DW-1:0] ev, logic [DW-1:0] q);
		int gap;
		gap = pick_gap(src_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {q, ev, et, idx};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(playback_predict(act, idx, et, ev, q));
		items_sent++;
	endtask

	task automatic send_load(int slot, logic [DW-1:0] t, logic [DW-1:0] v);
		send_item(ACT_LOAD, slot[7:0], t, v, $urandom());
	endtask

	task automatic send_query(logic [ACTION_W-1:0] act, logic [DW-1:0] q);
		send_item(act, 8'($urandom()), $urandom(), $urandom(), q);
	endtask

	// Hold off until every result is back, then let the block settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_entry_count(int n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= n[COUNT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		count_reg = n;
		cfg_valid <= 1'b0;
	endtask

	// Load slots 0..n-1 with ascending times, some of them repeated.
	task automatic load_ramp(int n);
		longint t;
		int step_max;
		step_max = (n > 32) ? (1 << 22) : (1 << 26);
		t = -longint'($urandom_range(0, 1 << 30));
		for (int i = 0; i < n; i++) begin
			send_load(i, t[DW-1:0], $urandom());
			if ($urandom_range(0, 9) != 0)
				t = t + $urandom_range(1, step_max);
		end
	endtask

	// Pick a query time around the loaded breakpoints.
	function automatic logic [DW-1:0] pick_query();
		int s, n;
		longint a, b;
		n = used_entries();
		s = $urandom_range(0, n - 1);
		case ($urandom_range(0, 9))
			0: return bp_time[s];
			1: return $urandom();
			2: return bp_time[0] - $urandom_range(0, 1000);
			default: begin
				a = bp_time[s];
				b = (s + 1 < n) ? longint'(bp_time[s+1]) : a + 5000;
				if (b <= a)
					return bp_time[s];
				return DW'(a + longint'($urandom_range(0, 32'(b - a - 1))));
			end
		endcase
	endfunction

	// Mostly deliver/evaluate; a little noise of stray loads and unused codes.
	task automatic playback_mix(int k);
		int r;
		bit dlv;
		for (int i = 0; i < k; i++) begin
			r = $urandom_range(0, 99);
			dlv = (r < 55);
			if (r >= 95)
				send_query(ACT_UNUSED, $urandom());
			else if (r >= 90)
				send_load($urandom_range(0, DEPTH - 1), $urandom(), $urandom());
			else if (reads_loaded(dlv))
				send_query(dlv ? ACT_DELIVER : ACT_EVAL, pick_query());
			else
				send_query(ACT_UNUSED, $urandom());
		end
	endtask

	task automatic test_after_reset();
		send_query(ACT_UNUSED, $urandom());
		send_load(0, 32'sd1000, 32'sd77);
		send_query(ACT_EVAL, 32'sd999);
		send_query(ACT_EVAL, 32'sd1000);
		send_query(ACT_EVAL, 32'h7FFF_FFFF);
		send_query(ACT_DELIVER, 32'h8000_0000);
	endtask

	task automatic test_field_extremes();
		set_entry_count(5);
		send_load(0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_load(1, 32'sd0, 32'h8000_0000);
		send_load(2, 32'sd0, 32'h7FFF_FFFF);
		send_load(3, 32'sd100, -32'sd3);
		send_load(4, 32'h7FFF_FFFF, 32'sd5);
		send_query(ACT_DELIVER, 32'h8000_0001);
		send_query(ACT_EVAL, -32'sd1);
		send_query(ACT_DELIVER, 32'sd0);
		send_query(ACT_DELIVER, 32'sd50);
		send_query(ACT_DELIVER, 32'h7FFF_FFFE);
		// bound already at the end: no further advance
		send_query(ACT_DELIVER, 32'h7FFF_FFFF);
		send_query(ACT_EVAL, 32'sd99);
		send_query(ACT_EVAL, -32'sd5);
		// break the ordering and let the slope run past the data range
		send_load(2, 32'h8000_0002, 32'h7FFF_FFFF);
		send_query(ACT_DELIVER, 32'sd1);
		send_query(ACT_DELIVER, 32'sd1);
		send_query(ACT_DELIVER, 32'h7000_0000);
		send_query(ACT_UNUSED, 32'sd0);
		send_query(ACT_EVAL, 32'h7000_0000);
	endtask

	task automatic test_count_extremes();
		set_entry_count(256);
		load_ramp(256);
		src_calm = 1'b1;
		for (int i = 0; i < 270; i++)
			send_query(ACT_DELIVER, (i % 3 == 0) ? pick_query() : $urandom());
		src_calm = 1'b0;
		set_entry_count(511);
		playback_mix(40);
		set_entry_count(300);
		playback_mix(20);
		set_entry_count(0);
		playback_mix(20);
		set_entry_count(1);
		playback_mix(10);
	endtask

	task automatic test_random_playback();
		int n;
		while (items_sent < TARGET) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 16);
			set_entry_count(n);
			src_calm  = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			load_ramp(n);
			playback_mix($urandom_range(20, 60));
		end
		src_calm  = 1'b0;
		sink_calm = 1'b0;
	endtask

	// Randomly stall the result side, holding ready low for a whole gap.
	always @(posedge clk) begin
		if (sink_calm) begin
			m_axis_tready <= 1'b1;
		end else if (sink_hold > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold     <= sink_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
			sink_hold     <= pick_gap(1'b0);
		end
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		playback_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation: %h / %b", m_axis_tdata, m_axis_tuser);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== want.play) begin
					$error("play_value: expected %h, got %h", want.play, m_axis_tdata[31:0]);
					fail_count++;
				end
				if (m_axis_tuser[0] !== want.written) begin
					$error("value_written: expected %b, got %b", want.written, m_axis_tuser[0]);
					fail_count++;
				end
				if (m_axis_tdata[63:32] !== want.next_time) begin
					$error("next_event_time: expected %h, got %h", want.next_time,
						m_axis_tdata[63:32]);
					fail_count++;
				end
				if (m_axis_tuser[1] !== want.next_valid) begin
					$error("next_event_valid: expected %b, got %b", want.next_valid,
						m_axis_tuser[1]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		items_sent  = 0;
		bound_idx   = 0;
		cursor_idx  = 0;
		count_reg   = 1;
		src_calm    = 1'b0;
		sink_calm   = 1'b0;
		for (int i = 0; i < DEPTH; i++)
			bp_written[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_field_extremes();
		test_count_extremes();
		test_random_playback();
		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

/* piecewise_linear_playback.f */
+incdir+rtl
rtl/plp_pkg.sv
rtl/plp_front.sv
rtl/plp_muldiv.sv
rtl/plp_back.sv
rtl/piecewise_linear_playback.sv
verif/tb_piecewise_linear_playback.sv
